[rtl/ilp_pkg.sv]
package ilp_pkg;

  // Width of the parsed value; the result port is always 64 bits, sign-extended.
  localparam int VALUE_BITS = 64;
  localparam int OUT_BITS   = 64;
  // Magnitude holds up to 2^(VALUE_BITS-1), so it needs VALUE_BITS bits.
  localparam int MAG_BITS   = VALUE_BITS;
  // Room for magnitude * 16 + 15.
  localparam int PROD_BITS  = VALUE_BITS + 5;

  localparam logic [7:0] CH_PLUS    = 8'h2B;
  localparam logic [7:0] CH_MINUS   = 8'h2D;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_X_LOWER = 8'h78;
  localparam logic [7:0] CH_X_UPPER = 8'h58;

  localparam logic [4:0] NO_DIGIT = 5'd16;

  typedef enum logic [2:0] {
    PH_START,
    PH_BODY,
    PH_ZERO,
    PH_HEXPFX,
    PH_DIGITS
  } phase_t;

  typedef enum logic [1:0] {
    RDX_8,
    RDX_10,
    RDX_16
  } radix_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_SYNTAX   = 2'd1,
    ST_OVERFLOW = 2'd2
  } status_t;

  typedef struct packed {
    phase_t              phase;
    logic                negative;
    radix_t              radix;
    logic [MAG_BITS-1:0] magnitude;
    logic                bad;
    logic                overflowed;
  } state_t;

  // Registered input character, handed from the input stage to the step logic.
  typedef struct packed {
    logic       valid;
    logic [7:0] ch;
    logic       last;
  } in_item_t;

  localparam state_t STATE_RESET = '{
    phase:      PH_START,
    negative:   1'b0,
    radix:      RDX_10,
    magnitude:  '0,
    bad:        1'b0,
    overflowed: 1'b0
  };

  // Hex digit value of a character, NO_DIGIT when it is none.
  function automatic logic [4:0] digit_of(logic [7:0] c);
    logic [4:0] d;
    d = NO_DIGIT;
    if (c >= 8'h30 && c <= 8'h39) begin
      d = 5'(c - 8'h30);
    end else if (c >= 8'h41 && c <= 8'h46) begin
      d = 5'(c - 8'h37);
    end else if (c >= 8'h61 && c <= 8'h66) begin
      d = 5'(c - 8'h57);
    end
    return d;
  endfunction

  function automatic logic [4:0] radix_value(radix_t r);
    logic [4:0] v;
    unique case (r)
      RDX_8:   v = 5'd8;
      RDX_16:  v = 5'd16;
      default: v = 5'd10;
    endcase
    return v;
  endfunction

endpackage

[rtl/ilp_intf.sv]
interface ilp_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;
  logic       last;

  modport source (output valid, output ch, output last, input ready);
  modport sink (input valid, input ch, input last, output ready);
endinterface

interface ilp_result_if;
  logic               valid;
  logic               ready;
  logic signed [63:0] value;
  logic [1:0]         status;

  modport source (output valid, output value, output status, input ready);
  modport sink (input valid, input value, input status, output ready);
endinterface

[rtl/ilp_in_stage.sv]
module ilp_in_stage (
  input  logic             clk,
  input  logic             rst,
  ilp_char_if.sink         chars,
  input  logic             advance,
  output ilp_pkg::in_item_t item
);
  import ilp_pkg::*;

  logic       valid;
  logic [7:0] ch;
  logic       last;

  // Take a new character when none is held or the held one moves on this cycle.
  assign chars.ready = !valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (chars.valid && chars.ready) begin
      valid <= 1'b1;
    end else if (advance) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (chars.valid && chars.ready) begin
      ch   <= chars.ch;
      last <= chars.last;
    end
  end

  assign item = '{valid: valid, ch: ch, last: last};

endmodule

[rtl/ilp_step.sv]
module ilp_step (
  input  ilp_pkg::state_t  cur,
  input  logic [7:0]       ch,
  output ilp_pkg::state_t  nxt,
  output logic signed [63:0] value,
  output ilp_pkg::status_t status
);
  import ilp_pkg::*;

  localparam logic [PROD_BITS-1:0] LIM_WIDE = PROD_BITS'(1) << (VALUE_BITS - 1);
  localparam logic [MAG_BITS-1:0]  LIM_MAG  = MAG_BITS'(1) << (VALUE_BITS - 1);

  logic                   take;
  logic [4:0]             dv;
  logic [PROD_BITS-1:0]   m_ext;
  logic [PROD_BITS-1:0]   scaled;
  logic signed [VALUE_BITS-1:0] signed_val;

  assign dv    = digit_of(ch);
  assign m_ext = PROD_BITS'(cur.magnitude);

  always_comb begin
    nxt  = cur;
    take = 1'b0;
    if (!cur.bad) begin
      if (cur.phase == PH_START && (ch == CH_PLUS || ch == CH_MINUS)) begin
        nxt.negative = (ch == CH_MINUS);
        nxt.phase    = PH_BODY;
      end else if (cur.phase == PH_START || cur.phase == PH_BODY) begin
        if (ch == CH_ZERO) begin
          nxt.radix = RDX_8;
          nxt.phase = PH_ZERO;
        end else begin
          nxt.radix = RDX_10;
          nxt.phase = PH_DIGITS;
          take      = 1'b1;
        end
      end else if (cur.phase == PH_ZERO) begin
        if (ch == CH_X_LOWER || ch == CH_X_UPPER) begin
          nxt.radix = RDX_16;
          nxt.phase = PH_HEXPFX;
        end else begin
          nxt.phase = PH_DIGITS;
          take      = 1'b1;
        end
      end else begin
        nxt.phase = PH_DIGITS;
        take      = 1'b1;
      end
    end

    // magnitude * radix + digit, as shifts and adds
    unique case (nxt.radix)
      RDX_8:   scaled = (m_ext << 3) + PROD_BITS'(dv);
      RDX_16:  scaled = (m_ext << 4) + PROD_BITS'(dv);
      default: scaled = (m_ext << 3) + (m_ext << 1) + PROD_BITS'(dv);
    endcase

    if (take) begin
      if (dv >= radix_value(nxt.radix)) begin
        nxt.bad = 1'b1;
      end else if (!cur.overflowed) begin
        if (scaled > LIM_WIDE) begin
          nxt.overflowed = 1'b1;
        end else begin
          nxt.magnitude = scaled[MAG_BITS-1:0];
        end
      end
    end
  end

  // Word-end verdict, taken from the updated state.
  always_comb begin
    signed_val = '0;
    if (nxt.bad || nxt.phase == PH_START || nxt.phase == PH_BODY ||
        nxt.phase == PH_HEXPFX) begin
      status = ST_SYNTAX;
    end else if (nxt.overflowed || (!nxt.negative && nxt.magnitude >= LIM_MAG)) begin
      status = ST_OVERFLOW;
    end else begin
      status     = ST_OK;
      signed_val = nxt.negative ? -signed'(nxt.magnitude) : signed'(nxt.magnitude);
    end
  end

  assign value = OUT_BITS'(signed_val);

endmodule

[rtl/integer_literal_parser.sv]
// Integer literal parser. Feed the ASCII characters of one word on "chars",
// one character per transaction, with last set on the final character. An
// optional '+' or '-' may lead; a body of "0x"/"0X" plus digits is hex, any
// other body starting with '0' is octal, everything else is decimal. After
// the final character, exactly one transaction appears on "results" holding
// the signed 64-bit value and a status (0 ok, 1 bad digit / empty body /
// bare hex prefix, 2 out of range); value is zero unless status is ok.
// Characters that are not last produce no result. Rate: one character per
// clock, also across word boundaries, unless a final character waits on a
// stalled result; set by the combinational shift-add that updates the
// magnitude register from the registered character. A final character goes
// through the input register, then the result register. A stalled result only
// holds up the next final character; other characters flow into the word state.
module integer_literal_parser (
  input  logic          clk,
  input  logic          rst,
  ilp_char_if.sink      chars,
  ilp_result_if.source  results
);
  import ilp_pkg::*;

  in_item_t           item;
  state_t             state;
  state_t             state_next;
  logic signed [63:0] step_value;
  status_t            step_status;
  logic               out_free;
  logic               advance;

  // Output register is free when empty or being drained this cycle.
  assign out_free = !results.valid || results.ready;
  // A non-final character never needs the output register.
  assign advance  = item.valid && (!item.last || out_free);

  ilp_in_stage u_in_stage (
    .clk     (clk),
    .rst     (rst),
    .chars   (chars),
    .advance (advance),
    .item    (item)
  );

  ilp_step u_step (
    .cur    (state),
    .ch     (item.ch),
    .nxt    (state_next),
    .value  (step_value),
    .status (step_status)
  );

  // Word state: back to reset after the final character.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= STATE_RESET;
    end else if (advance) begin
      state <= item.last ? STATE_RESET : state_next;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      results.valid <= 1'b0;
    end else if (advance && item.last) begin
      results.valid <= 1'b1;
    end else if (results.ready) begin
      results.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && item.last) begin
      results.value  <= step_value;
      results.status <= step_status;
    end
  end

  // A word end produces a result and clears the word state.
  assert property (@(posedge clk) disable iff (rst)
    (advance && item.last) |=> (results.valid && state == STATE_RESET))
    else $error("word end did not produce a result or clear state");

  // A pending final character must not be overwritten while output is stalled.
  assert property (@(posedge clk) disable iff (rst)
    (results.valid && !results.ready && item.valid && item.last) |-> !chars.ready)
    else $error("input taken while final character is blocked");

  // Hex prefix state always carries radix 16.
  assert property (@(posedge clk) disable iff (rst)
    (state.phase == PH_HEXPFX) |-> (state.radix == RDX_16))
    else $error("hex prefix without hex radix");

  // A non-ok result carries a zero value.
  assert property (@(posedge clk) disable iff (rst)
    ($rose(results.valid) && results.status != ST_OK) |-> (results.value == '0))
    else $error("error result with nonzero value");

endmodule

[tb/sv/tb_top.sv]
// Self-checking bench for integer_literal_parser.
// A table of hand-picked words is sent first. Rows whose outcome is obvious
// (limits, error codes) carry their expected result. The remaining rows and a
// long stream of random words are checked against a cycle-free software
// parser kept in this module. Both the character sender and the result
// receiver insert random idle bursts, except in the closing stretch.
module tb_top;
  import ilp_pkg::*;

  typedef logic [7:0] char_q_t[$];

  // One parsed literal, as it appears on the result channel.
  typedef struct packed {
    logic signed [63:0] value;
    status_t            status;
  } literal_t;

  // Directed word: text, index of a character to replace with NUL (-1: none),
  // and an optional hand-written expectation.
  typedef struct {
    string              text;
    int                 nul_at;
    bit                 typed;
    logic signed [63:0] value;
    status_t            status;
  } word_row_t;

  localparam int          RANDOM_CHARS = 1000;
  localparam int          QUIET_AFTER  = 850;   // no idling past this many random chars
  localparam int          DRAIN_EVERY  = 400;   // sender waits for all results this often
  localparam logic [63:0] MAG_LIMIT    = 64'd1 << (VALUE_BITS - 1);
  localparam logic [63:0] S64_MAX      = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] S64_MIN      = 64'h8000_0000_0000_0000;

  logic clk;
  logic rst;

  ilp_char_if   char_ch();
  ilp_result_if res_ch();

  integer_literal_parser dut (
    .clk     (clk),
    .rst     (rst),
    .chars   (char_ch),
    .results (res_ch)
  );

  // Software copy of the word state.
  phase_t      word_phase;
  logic        word_neg;
  radix_t      word_radix;
  logic [63:0] word_mag;
  logic        word_bad;
  logic        word_ovf;

  literal_t expected_literals[$];
  int       errors   = 0;
  int       accepted = 0;   // characters taken by the DUT
  bit       quiet    = 1'b0;

  word_row_t directed_rows[] = '{
    '{"0",                     -1, 1'b1, 64'sd0,   ST_OK},        // lone zero
    '{"+",                     -1, 1'b1, 64'sd0,   ST_SYNTAX},    // sign with no body
    '{"-",                     -1, 1'b1, 64'sd0,   ST_SYNTAX},
    '{"4-2",                   -1, 1'b1, 64'sd0,   ST_SYNTAX},    // sign not in front
    '{"+-1",                   -1, 1'b1, 64'sd0,   ST_SYNTAX},
    '{"0x",                    -1, 1'b1, 64'sd0,   ST_SYNTAX},    // bare hex prefix
    '{"-0X",                   -1, 1'b1, 64'sd0,   ST_SYNTAX},
    '{"05",                    -1, 1'b1, 64'sd5,   ST_OK},        // leading zero = octal
    '{"08",                    -1, 1'b1, 64'sd0,   ST_SYNTAX},    // 8 is no octal digit
    '{"0xx1",                  -1, 1'b1, 64'sd0,   ST_SYNTAX},    // second x
    '{"7z",                    -1, 1'b1, 64'sd0,   ST_SYNTAX},
    '{"1@",                     1, 1'b1, 64'sd0,   ST_SYNTAX},    // NUL character
    '{"9223372036854775807",   -1, 1'b1, S64_MAX,  ST_OK},
    '{"-9223372036854775808",  -1, 1'b1, S64_MIN,  ST_OK},
    '{"9223372036854775808",   -1, 1'b1, 64'sd0,   ST_OVERFLOW},
    '{"-9223372036854775809",  -1, 1'b1, 64'sd0,   ST_OVERFLOW},
    '{"0x7FFFFFFFFFFFFFFF",    -1, 1'b1, S64_MAX,  ST_OK},
    '{"-0x8000000000000000",   -1, 1'b1, S64_MIN,  ST_OK},
    '{"0X10000000000000000",   -1, 1'b1, 64'sd0,   ST_OVERFLOW},
    '{"99999999999999999999z", -1, 1'b1, 64'sd0,   ST_SYNTAX},    // bad digit beats overflow
    '{"+0xDeadBeef",           -1, 1'b0, 64'sd0,   ST_OK},
    '{"-0777",                 -1, 1'b0, 64'sd0,   ST_OK},
    '{"+123",                  -1, 1'b0, 64'sd0,   ST_OK},
    '{"0XaBcDeF",              -1, 1'b0, 64'sd0,   ST_OK}
  };

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop well beyond the slowest legal run.
  initial begin
    #3000000;
    $display("Test completed with failures");
    $finish;
  end

  function automatic void clear_word();
    word_phase = PH_START;
    word_neg   = 1'b0;
    word_radix = RDX_10;
    word_mag   = '0;
    word_bad   = 1'b0;
    word_ovf   = 1'b0;
  endfunction

  function automatic logic [4:0] hex_value(logic [7:0] c);
    if (c >= "0" && c <= "9") return 5'(c - "0");
    if (c >= "A" && c <= "F") return 5'(c - "A" + 10);
    if (c >= "a" && c <= "f") return 5'(c - "a" + 10);
    return NO_DIGIT;
  endfunction

  // Shift one digit into the magnitude; flags a character that is no digit of
  // the current radix or a magnitude that would pass 2^(VALUE_BITS-1).
  function automatic void take_digit(logic [7:0] c);
    logic [63:0] dv;
    logic [63:0] rdx;
    dv = 64'(hex_value(c));
    case (word_radix)
      RDX_8:   rdx = 64'd8;
      RDX_16:  rdx = 64'd16;
      default: rdx = 64'd10;
    endcase
    if (dv >= rdx) begin
      word_bad = 1'b1;
    end else if (!word_ovf) begin
      if (word_mag > (MAG_LIMIT - dv) / rdx) begin
        word_ovf = 1'b1;
      end else begin
        word_mag = word_mag * rdx + dv;
      end
    end
  endfunction

  // Advance the word state by one character; returns 1 with the literal
  // when the character ends the word.
  function automatic bit parse_char(logic [7:0] c, logic fin, output literal_t res);
    res.value  = '0;
    res.status = ST_OK;
    if (!word_bad) begin
      if (word_phase == PH_START && (c == CH_PLUS || c == CH_MINUS)) begin
        word_neg   = (c == CH_MINUS);
        word_phase = PH_BODY;
      end else if (word_phase == PH_START || word_phase == PH_BODY) begin
        if (c == CH_ZERO) begin
          word_radix = RDX_8;
          word_phase = PH_ZERO;
        end else begin
          word_radix = RDX_10;
          word_phase = PH_DIGITS;
          take_digit(c);
        end
      end else if (word_phase == PH_ZERO) begin
        if (c == CH_X_LOWER || c == CH_X_UPPER) begin
          word_radix = RDX_16;
          word_phase = PH_HEXPFX;
        end else begin
          word_phase = PH_DIGITS;
          take_digit(c);
        end
      end else begin
        word_phase = PH_DIGITS;
        take_digit(c);
      end
    end
    if (!fin) return 1'b0;

    if (word_bad || word_phase == PH_START || word_phase == PH_BODY ||
        word_phase == PH_HEXPFX) begin
      res.status = ST_SYNTAX;
    end else if (word_ovf || (!word_neg && word_mag >= MAG_LIMIT)) begin
      // 2^(VALUE_BITS-1) only fits as a negative number
      res.status = ST_OVERFLOW;
    end else begin
      res.value = word_neg ? 64'd0 - word_mag : word_mag;
    end
    clear_word();
    return 1'b1;
  endfunction

  // Feed one word, one character per transaction. Typed rows replace the
  // parser's result with the hand-written one.
  task automatic send_word(char_q_t w, bit typed, literal_t typed_res);
    literal_t res;
    bit       calm;
    bit       fin;
    calm = quiet || ($urandom_range(0, 3) == 0);
    foreach (w[i]) begin
      fin = (i == w.size() - 1);
      char_ch.valid <= 1'b1;
      char_ch.ch    <= w[i];
      char_ch.last  <= fin;
      @(posedge clk);
      while (!char_ch.ready) @(posedge clk);
      accepted++;
      if (parse_char(w[i], fin, res)) begin
        expected_literals.push_back(typed ? typed_res : res);
      end
      if (!calm && $urandom_range(0, 4) == 0) begin
        char_ch.valid <= 1'b0;
        repeat ($urandom_range(1, 3)) @(posedge clk);
      end
    end
  endtask

  task automatic wait_drained();
    char_ch.valid <= 1'b0;
    while (expected_literals.size() != 0) @(posedge clk);
  endtask

  // Mostly well-formed literals (some right at the signed limit), plus words
  // with one corrupted character, raw byte noise and sign/prefix stubs.
  task automatic make_random_word(output char_q_t w);
    int          kind;
    int          sign;
    logic [63:0] mag;
    logic [7:0]  c;
    string       pfx;
    string       body;
    string       text;
    w    = {};
    kind = $urandom_range(0, 19);
    if (kind == 17 || kind == 18) begin
      repeat ($urandom_range(1, 6)) w.push_back(8'($urandom_range(0, 255)));
      return;
    end
    if (kind == 19) begin
      case ($urandom_range(0, 4))
        0:       text = "+";
        1:       text = "-";
        2:       text = "0x";
        3:       text = "-0X";
        default: text = "+0x";
      endcase
    end else begin
      if ($urandom_range(0, 7) == 0) begin
        mag = MAG_LIMIT - 64'd3 + 64'($urandom_range(0, 6));
      end else if ($urandom_range(0, 3) == 0) begin
        mag = {$urandom, $urandom} >> $urandom_range(0, 63);
      end else begin
        mag = {$urandom, $urandom} >> $urandom_range(36, 63);
      end
      case ($urandom_range(0, 2))
        0: body = $sformatf("%0d", mag);
        1: body = {"0", $sformatf("%0o", mag)};
        default: begin
          pfx  = $urandom_range(0, 1) ? "0x" : "0X";
          body = {pfx, $sformatf("%0h", mag)};
        end
      endcase
      sign = $urandom_range(0, 2);
      if (sign == 1) text = {"+", body};
      else if (sign == 2) text = {"-", body};
      else text = body;
    end
    for (int i = 0; i < text.len(); i++) begin
      c = text[i];
      // flip hex letters to upper case at random (ASCII case bit)
      if (c >= "a" && c <= "f" && $urandom_range(0, 1) == 1) c = c - 8'h20;
      w.push_back(c);
    end
    if (kind >= 14 && kind <= 16) begin
      w[$urandom_range(0, w.size() - 1)] = 8'($urandom_range(0, 255));
    end
  endtask

  function automatic void check_literal(logic signed [63:0] value, logic [1:0] status);
    literal_t exp;
    if (expected_literals.size() == 0) begin
      errors++;
      $display("%0t: unexpected result value %0d status %0d", $time, value, status);
      return;
    end
    exp = expected_literals.pop_front();
    if (value !== exp.value) begin
      errors++;
      $display("%0t: value expected %0d actual %0d", $time, exp.value, value);
    end
    if (status !== exp.status) begin
      errors++;
      $display("%0t: status expected %0d actual %0d", $time, exp.status, status);
    end
  endfunction

  // Result side: check each transaction, stall ready in short random bursts.
  initial begin
    int stall;
    stall = 0;
    res_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && res_ch.valid && res_ch.ready) check_literal(res_ch.value, res_ch.status);
      if (rst) begin
        res_ch.ready <= 1'b0;
      end else if (stall > 0) begin
        res_ch.ready <= 1'b0;
        stall--;
      end else begin
        res_ch.ready <= 1'b1;
        if (!quiet && $urandom_range(0, 5) == 0) stall = $urandom_range(1, 3);
      end
    end
  end

  // Character side: reset, directed table, then random words.
  initial begin
    char_q_t w;
    int      base;
    int      drain_at;
    rst           <= 1'b1;
    char_ch.valid <= 1'b0;
    char_ch.ch    <= '0;
    char_ch.last  <= 1'b0;
    clear_word();
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[r]) begin
      w = {};
      for (int i = 0; i < directed_rows[r].text.len(); i++) begin
        w.push_back(directed_rows[r].text[i]);
      end
      if (directed_rows[r].nul_at >= 0) w[directed_rows[r].nul_at] = 8'h00;
      send_word(w, directed_rows[r].typed,
                literal_t'{directed_rows[r].value, directed_rows[r].status});
    end
    wait_drained();

    base     = accepted;
    drain_at = DRAIN_EVERY;
    while (accepted - base < RANDOM_CHARS) begin
      quiet = (accepted - base) >= QUIET_AFTER;
      if (accepted - base >= drain_at) begin
        wait_drained();
        drain_at += DRAIN_EVERY;
      end
      make_random_word(w);
      send_word(w, 1'b0, literal_t'{64'sd0, ST_OK});
    end

    wait_drained();
    // keep the clock running to catch any stray result
    repeat (10) @(posedge clk);
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
